// ===== rtl/core/lkvc_pkg.sv =====
// lkvc_pkg: shared types and constants of the lru key-value cache
// request and response payloads, controller commands, table sizes
// no dependencies
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   write_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [VAL_W-1:0]   read_value;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lkvc_ctrl.sv =====
// lkvc_ctrl: request sequencer and output handshake of the lru key-value cache
// steps each transaction through capture, lookup and update
// depends on lkvc_pkg
`default_nettype none

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;
    logic   do_update;
    logic   accept;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign do_update = (state_reg == ST_UPDATE) && slot_free;
    assign req_ready = (state_reg == ST_IDLE) || do_update;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (do_update)
                begin
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (do_update)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign cmd.capture = accept;
    assign cmd.lookup  = (state_reg == ST_LOOKUP);
    assign cmd.update  = do_update;

endmodule

`default_nettype wire

// ===== rtl/core/lkvc_datapath.sv =====
// lkvc_datapath: key/value table, recency ranks, occupancy and capacity
// parallel key match and lru select in lookup, table update and response in update
// depends on lkvc_pkg
`default_nettype none

module lkvc_datapath
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  req_t             req,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    output rsp_t             rsp
);

    logic [KEY_W-1:0] key_reg   [ENTRIES];
    logic [VAL_W-1:0] value_reg [ENTRIES];
    logic [IDX_W-1:0] rank_reg  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] cap_reg;
    req_t             req_reg;
    rsp_t             rsp_reg;

    // lookup results
    logic             lk_hit_reg;
    logic [IDX_W-1:0] lk_hit_idx_reg;
    logic [IDX_W-1:0] lk_hit_rank_reg;
    logic             lk_full_reg;
    logic [IDX_W-1:0] lk_lru_idx_reg;
    logic [IDX_W-1:0] lk_ins_idx_reg;
    logic [VAL_W-1:0] lk_value_reg;
    logic [KEY_W-1:0] lk_lru_key_reg;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] lru_vec;
    logic [ENTRIES-1:0] avail;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   lru_idx;
    logic [IDX_W-1:0]   ins_idx;
    logic [IDX_W-1:0]   oldest_rank;
    logic [CNT_W-1:0]   eff_cap;
    logic               full;
    logic               ins_miss;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(ENTRIES))
        begin
            eff_cap = CNT_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign full        = (occ_reg != '0) && (occ_reg >= eff_cap);
    assign oldest_rank = IDX_W'(occ_reg - CNT_W'(1));

    always_comb
    begin
        hit_idx = '0;
        lru_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]   = valid_reg[i] && (key_reg[i] == req_reg.key);
            lru_vec[i] = valid_reg[i] && (rank_reg[i] == oldest_rank);
            if (match[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (lru_vec[i])
            begin
                lru_idx = lru_idx | IDX_W'(i);
            end
        end
    end

    // first free slot, counting the lru slot as free when it will be evicted
    assign avail = ~valid_reg | (full ? lru_vec : '0);

    always_comb
    begin
        ins_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                ins_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.lookup)
        begin
            lk_hit_reg      <= |match;
            lk_hit_idx_reg  <= hit_idx;
            lk_hit_rank_reg <= rank_reg[hit_idx];
            lk_full_reg     <= full;
            lk_lru_idx_reg  <= lru_idx;
            lk_ins_idx_reg  <= ins_idx;
            lk_value_reg    <= value_reg[hit_idx];
            lk_lru_key_reg  <= key_reg[lru_idx];
        end
    end

    assign ins_miss = (req_reg.req_type == REQ_INSERT) && !lk_hit_reg;

    // key and value storage
    always_ff @(posedge clk)
    begin
        if (cmd.update && req_reg.req_type == REQ_INSERT)
        begin
            if (lk_hit_reg)
            begin
                value_reg[lk_hit_idx_reg] <= req_reg.write_value;
            end
            else
            begin
                key_reg[lk_ins_idx_reg]   <= req_reg.key;
                value_reg[lk_ins_idx_reg] <= req_reg.write_value;
            end
        end
    end

    // response
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            rsp_reg.hit         <= lk_hit_reg;
            rsp_reg.read_value  <= (req_reg.req_type == REQ_READ && lk_hit_reg)
                                   ? lk_value_reg : '0;
            rsp_reg.evicted     <= ins_miss && lk_full_reg;
            rsp_reg.evicted_key <= (ins_miss && lk_full_reg) ? lk_lru_key_reg : '0;
        end
    end

    // valid bits, recency ranks, occupancy, capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CNT_W'(ENTRIES);
            for (int j = 0; j < ENTRIES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.update)
            begin
                unique case (req_reg.req_type)
                    REQ_READ, REQ_INSERT:
                    begin
                        if (lk_hit_reg)
                        begin
                            for (int j = 0; j < ENTRIES; j++)
                            begin
                                if (IDX_W'(j) == lk_hit_idx_reg)
                                begin
                                    rank_reg[j] <= '0;
                                end
                                else if (valid_reg[j] && rank_reg[j] < lk_hit_rank_reg)
                                begin
                                    rank_reg[j] <= rank_reg[j] + IDX_W'(1);
                                end
                            end
                        end
                        else if (req_reg.req_type == REQ_INSERT)
                        begin
                            for (int j = 0; j < ENTRIES; j++)
                            begin
                                if (IDX_W'(j) == lk_ins_idx_reg)
                                begin
                                    valid_reg[j] <= 1'b1;
                                    rank_reg[j]  <= '0;
                                end
                                else if (lk_full_reg && IDX_W'(j) == lk_lru_idx_reg)
                                begin
                                    valid_reg[j] <= 1'b0;
                                    rank_reg[j]  <= '0;
                                end
                                else if (valid_reg[j])
                                begin
                                    rank_reg[j] <= rank_reg[j] + IDX_W'(1);
                                end
                            end
                            if (!lk_full_reg)
                            begin
                                occ_reg <= occ_reg + CNT_W'(1);
                            end
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (lk_hit_reg)
                        begin
                            for (int j = 0; j < ENTRIES; j++)
                            begin
                                if (IDX_W'(j) == lk_hit_idx_reg)
                                begin
                                    valid_reg[j] <= 1'b0;
                                    rank_reg[j]  <= '0;
                                end
                                else if (valid_reg[j] && rank_reg[j] > lk_hit_rank_reg)
                                begin
                                    rank_reg[j] <= rank_reg[j] - IDX_W'(1);
                                end
                            end
                            occ_reg <= occ_reg - CNT_W'(1);
                        end
                    end
                    REQ_CLEAR:
                    begin
                        valid_reg <= '0;
                        occ_reg   <= '0;
                        for (int j = 0; j < ENTRIES; j++)
                        begin
                            rank_reg[j] <= '0;
                        end
                    end
                    default:
                    begin
                        valid_reg <= valid_reg;
                    end
                endcase
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// lru_key_value_cache: fully associative key-value cache with lru replacement
// top level joining lkvc_ctrl and lkvc_datapath
// depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath
//
//   channel | signals                        | payload
//   --------+--------------------------------+---------------------------------
//   request | req_valid / req_ready          | req: req_type, key, write_value
//   result  | rsp_valid / rsp_ready          | rsp: hit, read_value, evicted,
//           |                                |      evicted_key
//   config  | cfg_we                         | cfg_data: capacity
//
// a transaction is captured on accept, then looked up, then updated; its result is
// registered in the update step; back-to-back requests overlap (lookup over all 16 key
// comparators, then the table update, which also accepts the next request)
// reset empties the table and sets capacity to 16 at once, no clearing pass
// a result held by rsp_ready low stalls the update cycle of the next request

`default_nettype none

module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data
);

    dp_cmd_t cmd;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    lkvc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

    a_capture_then_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.lookup
    ) else $error("captured transaction not looked up next cycle");

    a_no_accept_in_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.lookup |-> !req_ready && !cmd.update
    ) else $error("accept or update during lookup");

    a_update_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.update |=> rsp_valid
    ) else $error("update without result");

endmodule

`default_nettype wire
